### sv/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, codes and constant tables of the 4-bit character LCD
// command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

  // Command codes on the request channel
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_LOCATE = 3'd2,
    OP_PUTCH  = 3'd3,
    OP_GLYPH  = 3'd4
  } op_t;

  // Kind of work queued for the back end
  typedef enum logic {
    K_INIT  = 1'b0,
    K_BYTES = 1'b1
  } kind_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_WAKE  = 2'd1,
    BK_INIT  = 2'd2,
    BK_BYTES = 2'd3
  } back_state_t;

  // Three patterns per nibble: enable low, enable high, enable low
  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_STROBE = 2'd1,
    PH_HOLD   = 2'd2
  } phase_t;

  localparam int EXTRA_W = 13;
  localparam int HOLD_W  = 15;

  localparam logic [HOLD_W-1:0]  HOLD_WAKE    = 15'd20000;
  localparam logic [EXTRA_W-1:0] EXTRA_BYTE   = 13'd53;
  localparam logic [EXTRA_W-1:0] EXTRA_CLEAR  = 13'd2053;
  localparam logic [3:0]         INIT_LAST    = 4'd13;
  localparam logic [4:0]         BYTE_LAST    = 5'd1;
  localparam logic [4:0]         GLYPH_LAST   = 5'd17;
  localparam logic [7:0]         CMD_CLEAR    = 8'h01;
  localparam logic [7:0]         DDRAM_SET    = 8'h80;
  localparam logic [1:0]         CGRAM_SET    = 2'b01;

  // Work item between front and back end
  typedef struct packed {
    kind_t               kind;
    logic                rs_first;
    logic [7:0]          first_byte;
    logic [EXTRA_W-1:0]  first_extra;
    logic                glyph;
    logic [63:0]         rows;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // DDRAM row start addresses
  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

  // Init nibble stream: wake-up 3,3,3,2 then bytes 28 08 01 06 0c
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd7:             nib = 4'h8;
      4'd9:             nib = 4'h1;
      4'd11:            nib = 4'h6;
      4'd12:            nib = 4'h0;
      4'd13:            nib = 4'hC;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  // Extra hold added to the final pattern of each init nibble
  function automatic logic [EXTRA_W-1:0] init_extra(input logic [3:0] idx);
    logic [EXTRA_W-1:0] ext;
    case (idx)
      4'd0:                          ext = 13'd5000;
      4'd1:                          ext = 13'd200;
      4'd2, 4'd3, 4'd5, 4'd7:        ext = EXTRA_BYTE;
      4'd9:                          ext = 13'd2213;
      4'd11, 4'd13:                  ext = EXTRA_BYTE;
      default:                       ext = '0;
    endcase
    return ext;
  endfunction

endpackage

`default_nettype wire

### sv/lcd4_cmd_if.sv
// ----------------------------------------------------------------------------
// lcd4_cmd_if
// Command request channel: valid/ready handshake plus command fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcd4_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  row;
  logic [4:0]  column;
  logic [7:0]  char_code;
  logic [2:0]  glyph_slot;
  logic [63:0] glyph_rows;

  modport source (
    output valid, operation, row, column, char_code, glyph_slot, glyph_rows,
    input  ready
  );
  modport sink (
    input  valid, operation, row, column, char_code, glyph_slot, glyph_rows,
    output ready
  );
endinterface

`default_nettype wire

### sv/lcd4_pat_if.sv
// ----------------------------------------------------------------------------
// lcd4_pat_if
// Pin pattern channel: valid/ready handshake plus pattern, hold and last.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcd4_pat_if;
  logic        valid;
  logic        ready;
  logic [5:0]  port_value;
  logic [14:0] hold_us;
  logic        last;

  modport source (
    output valid, port_value, hold_us, last,
    input  ready
  );
  modport sink (
    input  valid, port_value, hold_us, last,
    output ready
  );
endinterface

`default_nettype wire

### sv/lcd4_front.sv
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts command requests and classifies them into queue work items.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_front (
  lcd4_cmd_if.sink                 cmd,
  input  lcd4_pkg::queue_status_t  q_stat,
  output logic                     push,
  output lcd4_pkg::desc_t          desc
);

  logic       known;
  logic [7:0] locate_byte;

  // Requests are taken whenever the queue has room; unknown codes are dropped
  assign cmd.ready = !q_stat.full;

  assign locate_byte = (lcd4_pkg::row_offset(cmd.row) + {3'b000, cmd.column})
                       | lcd4_pkg::DDRAM_SET;

  // Command decode
  always_comb begin
    known            = 1'b1;
    desc.kind        = lcd4_pkg::K_BYTES;
    desc.rs_first    = 1'b0;
    desc.first_byte  = lcd4_pkg::CMD_CLEAR;
    desc.first_extra = lcd4_pkg::EXTRA_BYTE;
    desc.glyph       = 1'b0;
    desc.rows        = cmd.glyph_rows;
    case (cmd.operation)
      lcd4_pkg::OP_INIT: begin
        desc.kind = lcd4_pkg::K_INIT;
      end
      lcd4_pkg::OP_CLEAR: begin
        desc.first_extra = lcd4_pkg::EXTRA_CLEAR;
      end
      lcd4_pkg::OP_LOCATE: begin
        desc.first_byte = locate_byte;
      end
      lcd4_pkg::OP_PUTCH: begin
        desc.rs_first   = 1'b1;
        desc.first_byte = cmd.char_code;
      end
      lcd4_pkg::OP_GLYPH: begin
        desc.first_byte = {lcd4_pkg::CGRAM_SET, cmd.glyph_slot, 3'b000};
        desc.glyph      = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = cmd.valid && cmd.ready && known;

endmodule

`default_nettype wire

### sv/lcd4_queue.sv
// ----------------------------------------------------------------------------
// lcd4_queue
// Short FIFO of work items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_queue #(
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  lcd4_pkg::desc_t          push_data,
  input  logic                     pop,
  output lcd4_pkg::desc_t          pop_data,
  output lcd4_pkg::queue_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lcd4_pkg::desc_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_FULL);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/lcd4_back.sv
// ----------------------------------------------------------------------------
// lcd4_back
// Expands queued work items into timed pin patterns, one per cycle while the
// pattern receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_back (
  input  logic                     clk,
  input  logic                     rst,
  input  lcd4_pkg::queue_status_t  q_stat,
  input  lcd4_pkg::desc_t          q_data,
  output logic                     pop,
  output logic                     idle,
  lcd4_pat_if.source               pat
);

  lcd4_pkg::back_state_t state;
  lcd4_pkg::back_state_t state_next;
  lcd4_pkg::phase_t      phase;

  logic [4:0]                   nib_idx;
  logic [71:0]                  byte_sr;
  logic                         rs_first;
  logic [lcd4_pkg::EXTRA_W-1:0] first_extra;
  logic                         glyph;

  logic                         pat_valid;
  logic [5:0]                   pat_port;
  logic [lcd4_pkg::HOLD_W-1:0]  pat_hold;
  logic                         pat_last;

  logic                         step;
  logic                         cur_rs;
  logic [3:0]                   cur_nib;
  logic [lcd4_pkg::EXTRA_W-1:0] cur_extra;
  logic                         nib_last;
  logic [5:0]                   p_port;
  logic [lcd4_pkg::HOLD_W-1:0]  p_hold;
  logic                         p_last;

  assign idle = (state == lcd4_pkg::BK_IDLE);
  assign pop  = idle && !q_stat.empty;
  assign step = !idle && (!pat_valid || pat.ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lcd4_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (q_data.kind == lcd4_pkg::K_INIT) ? lcd4_pkg::BK_WAKE
                                                         : lcd4_pkg::BK_BYTES;
        end
      end
      lcd4_pkg::BK_WAKE: begin
        if (step) state_next = lcd4_pkg::BK_INIT;
      end
      lcd4_pkg::BK_INIT, lcd4_pkg::BK_BYTES: begin
        if (step && p_last) state_next = lcd4_pkg::BK_IDLE;
      end
      default: state_next = lcd4_pkg::BK_IDLE;
    endcase
  end

  // Current nibble source: init table or the byte shift register
  always_comb begin
    if (state == lcd4_pkg::BK_INIT) begin
      cur_rs    = 1'b0;
      cur_nib   = lcd4_pkg::init_nibble(nib_idx[3:0]);
      cur_extra = lcd4_pkg::init_extra(nib_idx[3:0]);
      nib_last  = (nib_idx[3:0] == lcd4_pkg::INIT_LAST);
    end else begin
      cur_rs    = (nib_idx[4:1] == '0) ? rs_first : 1'b1;
      cur_nib   = nib_idx[0] ? byte_sr[3:0] : byte_sr[7:4];
      if (!nib_idx[0]) begin
        cur_extra = '0;
      end else if (nib_idx == lcd4_pkg::BYTE_LAST) begin
        cur_extra = first_extra;
      end else begin
        cur_extra = lcd4_pkg::EXTRA_BYTE;
      end
      nib_last  = (nib_idx == (glyph ? lcd4_pkg::GLYPH_LAST : lcd4_pkg::BYTE_LAST));
    end
  end

  // Pattern for this step
  always_comb begin
    p_port = {cur_rs, (phase == lcd4_pkg::PH_STROBE), cur_nib};
    p_last = 1'b0;
    case (phase)
      lcd4_pkg::PH_SETUP:  p_hold = '0;
      lcd4_pkg::PH_STROBE: p_hold = lcd4_pkg::HOLD_W'(1);
      lcd4_pkg::PH_HOLD: begin
        p_hold = lcd4_pkg::HOLD_W'(1) + lcd4_pkg::HOLD_W'(cur_extra);
        p_last = nib_last;
      end
      default:             p_hold = '0;
    endcase
    if (state == lcd4_pkg::BK_WAKE) begin
      p_port = '0;
      p_hold = lcd4_pkg::HOLD_WAKE;
      p_last = 1'b0;
    end
  end

  // State, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcd4_pkg::BK_IDLE;
      phase     <= lcd4_pkg::PH_SETUP;
      nib_idx   <= '0;
      pat_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step) begin
        pat_valid <= 1'b1;
      end else if (pat.ready) begin
        pat_valid <= 1'b0;
      end
      if (pop) begin
        phase   <= lcd4_pkg::PH_SETUP;
        nib_idx <= '0;
      end else if (step && state != lcd4_pkg::BK_WAKE) begin
        case (phase)
          lcd4_pkg::PH_SETUP:  phase <= lcd4_pkg::PH_STROBE;
          lcd4_pkg::PH_STROBE: phase <= lcd4_pkg::PH_HOLD;
          default: begin
            phase   <= lcd4_pkg::PH_SETUP;
            nib_idx <= nib_idx + 1'b1;
          end
        endcase
      end
    end
  end

  // Work item payload and byte shifter
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_sr     <= {q_data.rows, q_data.first_byte};
      rs_first    <= q_data.rs_first;
      first_extra <= q_data.first_extra;
      glyph       <= q_data.glyph;
    end else if (step && state == lcd4_pkg::BK_BYTES && phase == lcd4_pkg::PH_HOLD
                 && nib_idx[0]) begin
      byte_sr <= {8'h00, byte_sr[71:8]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (step) begin
      pat_port <= p_port;
      pat_hold <= p_hold;
      pat_last <= p_last;
    end
  end

  assign pat.valid      = pat_valid;
  assign pat.port_value = pat_port;
  assign pat.hold_us    = pat_hold;
  assign pat.last       = pat_last;

endmodule

`default_nettype wire

### sv/char_lcd_4bit_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_core
// 4-bit character LCD command sequencer: commands in, timed pin patterns out.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : command requests (init, clear, locate, put character, define glyph).
//         A request is taken whenever the work queue has room, so commands
//         can be posted back to back while earlier ones are still playing.
//         Codes 5..7 are accepted and produce nothing.
//   pat : pin patterns, several per command: port_value (data nibble, enable,
//         register select), hold_us and last on the final pattern.
//   A command accepted into an empty, idle block passes the work queue, the
//   sequencer state and the output register before its first pattern is valid.
//   Throughput: one pattern per cycle while the receiver is ready; the back
//   end pauses after each command to fetch the next queue entry. A command
//   gives 6 patterns for clear/locate/put character, 43 for init and 54 for
//   define glyph. The pattern sequencer is the limiting unit.
//   A stall on pat freezes the output register and the sequencer; the queue
//   keeps taking commands until it is full, then cmd.ready drops.
//   Reset empties the queue, returns the sequencer to idle and drops
//   pat.valid.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_command_sequencer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  lcd4_cmd_if.sink    cmd,
  lcd4_pat_if.source  pat
);

  lcd4_pkg::queue_status_t q_stat;
  lcd4_pkg::desc_t         push_desc;
  lcd4_pkg::desc_t         pop_desc;
  logic                    push;
  logic                    pop;
  logic                    back_idle;

  // Front end: accept and classify
  lcd4_front u_front (
    .cmd    (cmd),
    .q_stat (q_stat),
    .push   (push),
    .desc   (push_desc)
  );

  // Work queue
  lcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .pop_data  (pop_desc),
    .status    (q_stat)
  );

  // Back end: pattern sequencer
  lcd4_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (pop_desc),
    .pop    (pop),
    .idle   (back_idle),
    .pat    (pat)
  );

  // Queue never written while full
  assert property (@(posedge clk) disable iff (rst) !(push && q_stat.full))
    else $error("queue push while full");

  // An idle sequencer fetches pending work on the next edge
  assert property (@(posedge clk) disable iff (rst)
                   (back_idle && !q_stat.empty) |=> !back_idle)
    else $error("sequencer did not start pending work");

  // Hold time never exceeds the wake-up idle
  assert property (@(posedge clk) disable iff (rst)
                   pat.valid |-> (pat.hold_us <= lcd4_pkg::HOLD_WAKE))
    else $error("hold time out of range");

  // No pattern right after reset
  assert property (@(posedge clk) $past(rst) |-> !pat.valid)
    else $error("pattern valid after reset");

endmodule

`default_nettype wire
